// File: design/upd_pkg.sv
package upd_pkg;

  // Field and counter widths
  localparam int CountBits  = 16;
  localparam int CapBits    = 16;
  localparam int LenBits    = 16;
  localparam int ByteBits   = 8;
  localparam int CmpBits    = ((CountBits > CapBits) ? CountBits : CapBits) + 2;

  // One byte can cause up to three results
  localparam int MaxResults = 3;
  localparam int RemBits    = 2;

  localparam logic [CapBits-1:0]   CapReset = CapBits'(256);
  localparam logic [CountBits-1:0] CountMax = '1;

  // Characters
  localparam logic [ByteBits-1:0] ChNul     = 8'h00;
  localparam logic [ByteBits-1:0] ChPercent = 8'h25;
  localparam logic [ByteBits-1:0] ChPlus    = 8'h2B;
  localparam logic [ByteBits-1:0] ChSpace   = 8'h20;
  localparam logic [ByteBits-1:0] ChZero    = 8'h30;
  localparam logic [ByteBits-1:0] ChNine    = 8'h39;
  localparam logic [ByteBits-1:0] ChUpperA  = 8'h41;
  localparam logic [ByteBits-1:0] ChUpperF  = 8'h46;
  localparam logic [ByteBits-1:0] ChLowerA  = 8'h61;
  localparam logic [ByteBits-1:0] ChLowerF  = 8'h66;

  // Letters have low nibble 1..6; add this to get 10..15
  localparam logic [3:0] LetterOffset = 4'd9;

  typedef enum logic [1:0] {
    PendNone    = 2'd0,
    PendPercent = 2'd1,
    PendDigit   = 2'd2
  } pend_e;

  typedef struct packed {
    logic                 drop;
    pend_e                pend;
    logic [ByteBits-1:0]  digit;
    logic [CountBits-1:0] count;
  } state_t;

  typedef struct packed {
    logic [ByteBits-1:0] data;
    logic                end_mark;
    logic                status;
    logic [LenBits-1:0]  length;
  } result_t;

  function automatic logic is_digit(logic [ByteBits-1:0] c);
    return (c >= ChZero) && (c <= ChNine);
  endfunction

  function automatic logic is_hex(logic [ByteBits-1:0] c);
    return is_digit(c) ||
           ((c >= ChUpperA) && (c <= ChUpperF)) ||
           ((c >= ChLowerA) && (c <= ChLowerF));
  endfunction

  // Nibble value of a hex character; zero for anything else
  function automatic logic [3:0] hex_val(logic [ByteBits-1:0] c);
    logic [3:0] v;
    if (is_digit(c)) begin
      v = c[3:0];
    end else if (is_hex(c)) begin
      v = c[3:0] + LetterOffset;
    end else begin
      v = 4'd0;
    end
    return v;
  endfunction

endpackage

// File: design/upd_decode.sv
module upd_decode (
  input  upd_pkg::state_t                                  st_i,
  input  logic [upd_pkg::ByteBits-1:0]                     byte_i,
  input  logic [upd_pkg::CapBits-1:0]                      cap_i,
  output upd_pkg::state_t                                  st_o,
  output upd_pkg::result_t [upd_pkg::MaxResults-1:0]       res_o,
  output logic [upd_pkg::RemBits-1:0]                      cnt_o
);

  logic                              is_nul;
  logic                              byte_hex;
  logic                              active;
  logic                              term;
  logic                              set_pct;
  logic [upd_pkg::RemBits-1:0]       na;
  logic [upd_pkg::ByteBits-1:0]      att [upd_pkg::MaxResults];
  logic [upd_pkg::MaxResults-1:0]    full;
  logic [upd_pkg::CmpBits-1:0]       base;
  logic [upd_pkg::RemBits-1:0]       stop;
  logic                              ovf;
  logic [upd_pkg::CountBits-1:0]     count_sum;

  assign is_nul   = (byte_i == upd_pkg::ChNul);
  assign byte_hex = upd_pkg::is_hex(byte_i);

  // Build the list of characters to write for this byte
  always_comb begin
    active  = 1'b0;
    term    = 1'b0;
    set_pct = 1'b0;
    na      = '0;
    for (int i = 0; i < upd_pkg::MaxResults; i++) begin
      att[i] = upd_pkg::ChNul;
    end
    if (!st_i.drop) begin
      active = 1'b1;
      unique case (st_i.pend)
        upd_pkg::PendPercent: begin
          if (byte_hex) begin
            active = 1'b0;
          end else begin
            att[0] = upd_pkg::ChPercent;
            na     = upd_pkg::RemBits'(1);
          end
        end
        upd_pkg::PendDigit: begin
          if (byte_hex) begin
            att[0] = {upd_pkg::hex_val(st_i.digit), upd_pkg::hex_val(byte_i)};
            na     = upd_pkg::RemBits'(1);
          end else begin
            att[0] = upd_pkg::ChPercent;
            att[1] = st_i.digit;
            na     = upd_pkg::RemBits'(2);
          end
        end
        default: begin
          na = '0;
        end
      endcase
      // Plain handling of the new byte, unless it completed an escape
      if (active && !(st_i.pend == upd_pkg::PendDigit && byte_hex)) begin
        if (is_nul) begin
          term = 1'b1;
        end else if (byte_i == upd_pkg::ChPercent) begin
          set_pct = 1'b1;
        end else if (byte_i == upd_pkg::ChPlus) begin
          att[na] = upd_pkg::ChSpace;
          na      = na + upd_pkg::RemBits'(1);
        end else begin
          att[na] = byte_i;
          na      = na + upd_pkg::RemBits'(1);
        end
      end
    end
  end

  // Room check for the first, second and third write in parallel
  assign base = upd_pkg::CmpBits'(st_i.count);

  always_comb begin
    for (int k = 0; k < upd_pkg::MaxResults; k++) begin
      full[k] = ((base + upd_pkg::CmpBits'(k + 1)) >= upd_pkg::CmpBits'(cap_i)) ||
                ((base + upd_pkg::CmpBits'(k)) >= upd_pkg::CmpBits'(upd_pkg::CountMax));
    end
  end

  always_comb begin
    ovf  = 1'b1;
    stop = '0;
    priority if ((na > upd_pkg::RemBits'(0)) && full[0]) begin
      stop = upd_pkg::RemBits'(0);
    end else if ((na > upd_pkg::RemBits'(1)) && full[1]) begin
      stop = upd_pkg::RemBits'(1);
    end else if ((na > upd_pkg::RemBits'(2)) && full[2]) begin
      stop = upd_pkg::RemBits'(2);
    end else begin
      stop = na;
      ovf  = 1'b0;
    end
  end

  assign count_sum = st_i.count + upd_pkg::CountBits'(stop);
  assign cnt_o     = stop + upd_pkg::RemBits'(ovf | term);

  // Written characters first, then the terminator in the next slot
  always_comb begin
    for (int j = 0; j < upd_pkg::MaxResults; j++) begin
      if (upd_pkg::RemBits'(j) < stop) begin
        res_o[j].data     = att[j];
        res_o[j].end_mark = 1'b0;
        res_o[j].status   = 1'b0;
        res_o[j].length   = '0;
      end else begin
        res_o[j].data     = upd_pkg::ChNul;
        res_o[j].end_mark = 1'b1;
        res_o[j].status   = ovf;
        res_o[j].length   = upd_pkg::LenBits'(count_sum);
      end
    end
  end

  always_comb begin
    st_o = st_i;
    if (st_i.drop) begin
      if (is_nul) begin
        st_o = '0;
      end
    end else if (!active) begin
      st_o.pend  = upd_pkg::PendDigit;
      st_o.digit = byte_i;
    end else if (term) begin
      st_o = '0;
    end else begin
      st_o.count = count_sum;
      st_o.drop  = ovf;
      st_o.pend  = (set_pct && !ovf) ? upd_pkg::PendPercent : upd_pkg::PendNone;
    end
  end

endmodule

// File: design/upd_out_buf.sv
module upd_out_buf (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        load_i,
  input  upd_pkg::result_t [upd_pkg::MaxResults-1:0]  res_i,
  input  logic [upd_pkg::RemBits-1:0]                 cnt_i,
  input  logic                                        out_stall_i,
  output logic                                        out_valid_o,
  output upd_pkg::result_t                            head_o,
  output logic                                        free_o
);

  logic [upd_pkg::RemBits-1:0]                 rem_q;
  upd_pkg::result_t [upd_pkg::MaxResults-1:0]  res_q;
  logic                                        pop;

  assign out_valid_o = (rem_q != '0);
  assign pop         = out_valid_o && !out_stall_i;
  assign free_o      = (rem_q == '0) || ((rem_q == upd_pkg::RemBits'(1)) && pop);
  assign head_o      = res_q[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
    end else if (load_i) begin
      rem_q <= cnt_i;
    end else if (pop) begin
      rem_q <= rem_q - upd_pkg::RemBits'(1);
    end
  end

  // Advance the queue by one result per beat
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end else if (pop) begin
      res_q <= res_q >> $bits(upd_pkg::result_t);
    end
  end

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> free_o)
    else $error("result buffer loaded while holding undelivered results");

  a_stall_blocks_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> !free_o)
    else $error("result buffer reports room while stalled");

  a_term_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && head_o.end_mark) |-> (rem_q == upd_pkg::RemBits'(1)))
    else $error("terminator is not the last queued result");

endmodule

// File: design/url_percent_decoder.sv
// URL percent decoder. Takes one text byte per beat and returns decoded bytes;
// a zero byte closes the string with a terminator beat (end_mark_o = 1) that
// carries the status (0 ok, 1 overflow) and the decoded length. "%hh" with hex
// digits in either case decodes to one byte, '+' turns into a space, a broken
// escape is passed out literally and the following bytes are rescanned. At most
// out_capacity - 1 bytes are written per string; when that runs out the block
// sends an overflow terminator and swallows input up to the next zero byte.
// Timing: a byte is registered on accept and decoded once the result queue has
// room; its results are then registered into a three-entry result queue, which
// drives the output. Input is taken every cycle as long as each byte yields at
// most one result and the output is not stalled; a byte that yields more
// results holds the decoder until the queue has drained, since the queue drains
// one result per beat. No clearing pass after reset.
// cfg_wdata_i (out_capacity, reset 256) is written when cfg_we_i is high; write
// it only while the block is idle.
module url_percent_decoder (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // input byte channel
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [upd_pkg::ByteBits-1:0]     text_byte_i,
  // result channel
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [upd_pkg::ByteBits-1:0]     out_byte_o,
  output logic                             end_mark_o,
  output logic                             status_o,
  output logic [upd_pkg::LenBits-1:0]      decoded_len_o,
  // configuration
  input  logic                             cfg_we_i,
  input  logic [upd_pkg::CapBits-1:0]      cfg_wdata_i
);

  logic [upd_pkg::CapBits-1:0]                 cap_q;
  logic                                        in_full_q;
  logic [upd_pkg::ByteBits-1:0]                in_byte_q;
  upd_pkg::state_t                             st_q;
  upd_pkg::state_t                             st_d;
  upd_pkg::result_t [upd_pkg::MaxResults-1:0]  dec_res;
  logic [upd_pkg::RemBits-1:0]                 dec_cnt;
  upd_pkg::result_t                            head;
  logic                                        buf_free;
  logic                                        take;
  logic                                        accept;

  // Decode the held byte whenever the result queue can take its results
  assign take       = in_full_q && buf_free;
  assign in_stall_o = in_full_q && !take;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= upd_pkg::CapReset;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_full_q <= 1'b0;
      st_q      <= '0;
    end else begin
      if (accept) begin
        in_full_q <= 1'b1;
      end else if (take) begin
        in_full_q <= 1'b0;
      end
      if (take) begin
        st_q <= st_d;
      end
    end
  end

  // Input byte register; payload only
  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_byte_q <= text_byte_i;
    end
  end

  upd_decode u_decode (
    .st_i   (st_q),
    .byte_i (in_byte_q),
    .cap_i  (cap_q),
    .st_o   (st_d),
    .res_o  (dec_res),
    .cnt_o  (dec_cnt)
  );

  upd_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (take),
    .res_i       (dec_res),
    .cnt_i       (dec_cnt),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .head_o      (head),
    .free_o      (buf_free)
  );

  assign out_byte_o    = head.data;
  assign end_mark_o    = head.end_mark;
  assign status_o      = head.status;
  assign decoded_len_o = head.length;

  a_drop_no_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.drop |-> (st_q.pend == upd_pkg::PendNone))
    else $error("escape pending while dropping after overflow");

  a_digit_is_hex: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q.pend == upd_pkg::PendDigit) |-> upd_pkg::is_hex(st_q.digit))
    else $error("held escape digit is not a hex character");

  a_drop_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && st_q.drop) |=> !out_valid_o)
    else $error("dropped byte produced a result");

endmodule
